>>> rtl/piezo_strike_peak_trigger_assert.svh
// ----------------------------------------------------------------------------
// piezo strike peak trigger assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PIEZO_STRIKE_PEAK_TRIGGER_ASSERT_SVH
`define PIEZO_STRIKE_PEAK_TRIGGER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pspt_pkg.sv
// ----------------------------------------------------------------------------
// pspt_pkg
// types and constants shared by the piezo strike peak trigger
// ----------------------------------------------------------------------------
`default_nettype none

package pspt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DROOP_BITS  = 8;
    localparam int PITCH_BITS  = 7;

    // mode codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_WAIT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_DROOP       = 2'd1;
    localparam logic [1:0] CFG_DEAD_FRAMES = 2'd2;

    // configuration reset values
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET   = 16'd960;
    localparam logic [DROOP_BITS-1:0]  DROOP_RESET       = 8'd205;
    localparam logic [SAMPLE_BITS-1:0] DEAD_FRAMES_RESET = 16'd1102;

    // note number mapping: base + knob * span
    localparam logic [PITCH_BITS-1:0] PITCH_BASE = 7'd20;
    localparam logic [PITCH_BITS-1:0] PITCH_SPAN = 7'd80;
    localparam logic [PITCH_BITS-1:0] PITCH_MAX  = 7'd99;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] piezo_sample;
        logic [SAMPLE_BITS-1:0] pitch_knob;
        logic [SAMPLE_BITS-1:0] tone_knob;
    } pspt_in_t;

    typedef struct packed {
        logic                   led_on;
        logic                   note_start;
        logic [PITCH_BITS-1:0]  note_pitch;
        logic [SAMPLE_BITS-1:0] bright_velocity;
        logic [SAMPLE_BITS-1:0] dark_velocity;
    } pspt_out_t;

    typedef struct packed {
        logic [PITCH_BITS-1:0]  pitch;
        logic [SAMPLE_BITS-1:0] bright;
        logic [SAMPLE_BITS-1:0] dark;
    } pspt_note_t;

endpackage

`default_nettype wire

>>> rtl/pspt_note_calc.sv
// ----------------------------------------------------------------------------
// pspt_note_calc
// note number and two voice velocities from the knobs and the held peak
// ----------------------------------------------------------------------------
`default_nettype none

module pspt_note_calc (
    input  wire logic [pspt_pkg::SAMPLE_BITS-1:0] peak_level,
    input  wire logic [pspt_pkg::SAMPLE_BITS-1:0] pitch_knob,
    input  wire logic [pspt_pkg::SAMPLE_BITS-1:0] tone_knob,
    output pspt_pkg::pspt_note_t                  note
);

    localparam int SB = pspt_pkg::SAMPLE_BITS;
    localparam int PB = pspt_pkg::PITCH_BITS;

    logic [SB+PB-1:0] pitch_prod;
    logic [2*SB-1:0]  bright_prod;
    logic [2*SB:0]    dark_prod;
    logic [SB:0]      tone_inv;

    assign pitch_prod  = (SB+PB)'(pitch_knob) * (SB+PB)'(pspt_pkg::PITCH_SPAN);
    assign bright_prod = (2*SB)'(peak_level) * (2*SB)'(tone_knob);

    // full scale minus tone needs one extra bit
    assign tone_inv  = {1'b1, {SB{1'b0}}} - {1'b0, tone_knob};
    assign dark_prod = (2*SB+1)'(peak_level) * (2*SB+1)'(tone_inv);

    assign note.pitch  = pspt_pkg::PITCH_BASE + pitch_prod[SB+PB-1:SB];
    assign note.bright = bright_prod[2*SB-1:SB];
    assign note.dark   = dark_prod[2*SB-1:SB];

endmodule

`default_nettype wire

>>> rtl/piezo_strike_peak_trigger.sv
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle, set by the input register and result register
//   each advancing once per cycle while the output side takes results
// reset: rst_n clears mode, peak, dead count and the stage valids at once, and
//   returns the configuration registers to their defaults
// ----------------------------------------------------------------------------
// piezo_strike_peak_trigger
// strike detector with peak tracking, droop trigger and dead-time re-arm
// ----------------------------------------------------------------------------
`default_nettype none

module piezo_strike_peak_trigger (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pspt_pkg::pspt_in_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pspt_pkg::pspt_out_t       out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int SB = pspt_pkg::SAMPLE_BITS;
    localparam int DB = pspt_pkg::DROOP_BITS;

    // configuration
    logic [SB-1:0] threshold_reg;
    logic [DB-1:0] droop_reg;
    logic [SB-1:0] dead_frames_reg;

    // strike state
    logic [1:0]    mode_reg,  mode_next;
    logic [SB-1:0] peak_reg,  peak_next;
    logic [SB-1:0] dead_reg,  dead_next;

    // input stage and result stage
    logic                 stage_valid_reg;
    pspt_pkg::pspt_in_t   stage_item_reg;
    logic                 out_valid_reg;
    pspt_pkg::pspt_out_t  out_item_reg;
    pspt_pkg::pspt_out_t  out_item_next;

    logic                 advance;
    logic                 fire;
    logic [SB+DB-1:0]     droop_level;
    logic [SB-1:0]        dead_dec;
    pspt_pkg::pspt_note_t note;

    assign cfg_ready = 1'b1;
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    pspt_note_calc u_note_calc (
        .peak_level (peak_reg),
        .pitch_knob (stage_item_reg.pitch_knob),
        .tone_knob  (stage_item_reg.tone_knob),
        .note       (note)
    );

    assign droop_level = (SB+DB)'(droop_reg) * (SB+DB)'(peak_reg);
    assign dead_dec    = (dead_reg != '0) ? dead_reg - 1'b1 : dead_reg;

    always_comb
    begin
        mode_next = mode_reg;
        peak_next = peak_reg;
        dead_next = dead_reg;
        fire      = 1'b0;
        unique case (mode_reg)
            pspt_pkg::MODE_IDLE:
            begin
                if (stage_item_reg.piezo_sample > threshold_reg)
                begin
                    mode_next = pspt_pkg::MODE_TRACK;
                    peak_next = stage_item_reg.piezo_sample;
                end
            end
            pspt_pkg::MODE_TRACK:
            begin
                if (stage_item_reg.piezo_sample > peak_reg)
                begin
                    peak_next = stage_item_reg.piezo_sample;
                end
                else if ({stage_item_reg.piezo_sample, {DB{1'b0}}} < droop_level)
                begin
                    mode_next = pspt_pkg::MODE_WAIT;
                    dead_next = dead_frames_reg;
                    fire      = 1'b1;
                end
            end
            default:
            begin
                // waiting, and the unused code behaves the same
                dead_next = dead_dec;
                if (dead_dec == '0 && stage_item_reg.piezo_sample < threshold_reg)
                begin
                    mode_next = pspt_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_item_next.led_on          = (mode_next != pspt_pkg::MODE_IDLE);
        out_item_next.note_start      = fire;
        out_item_next.note_pitch      = fire ? note.pitch  : '0;
        out_item_next.bright_velocity = fire ? note.bright : '0;
        out_item_next.dark_velocity   = fire ? note.dark   : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= pspt_pkg::THRESHOLD_RESET;
            droop_reg       <= pspt_pkg::DROOP_RESET;
            dead_frames_reg <= pspt_pkg::DEAD_FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pspt_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_data;
                pspt_pkg::CFG_DROOP:       droop_reg       <= cfg_data[DB-1:0];
                pspt_pkg::CFG_DEAD_FRAMES: dead_frames_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= pspt_pkg::MODE_IDLE;
            peak_reg        <= '0;
            dead_reg        <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg <= mode_next;
                peak_reg <= peak_next;
                dead_reg <= dead_next;
            end

            if (in_valid && in_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_item_reg <= in_item;
        if (advance)
            out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

>>> rtl/pspt_checker.sv
// ----------------------------------------------------------------------------
// pspt_checker
// port-level checks on the result items of the strike trigger
// ----------------------------------------------------------------------------
`default_nettype none

`include "piezo_strike_peak_trigger_assert.svh"

module pspt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pspt_pkg::pspt_out_t out_item
);

    // a stalled result holds
    `PSPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result item changed")

    // a note is only sounded while a strike is active
    `PSPT_ASSERT_NOW(a_note_led, clk, rst_n, out_valid && out_item.note_start, out_item.led_on, "note without led")

    // note fields are zero on frames without a note
    `PSPT_ASSERT_NOW(a_quiet_zero, clk, rst_n, out_valid && !out_item.note_start, out_item.note_pitch == '0 && out_item.bright_velocity == '0 && out_item.dark_velocity == '0, "note fields set without note")

    // note number stays in the knob's range
    `PSPT_ASSERT_NOW(a_pitch_range, clk, rst_n, out_valid && out_item.note_start, out_item.note_pitch >= pspt_pkg::PITCH_BASE && out_item.note_pitch <= pspt_pkg::PITCH_MAX, "note number out of range")

endmodule

bind piezo_strike_peak_trigger pspt_checker u_pspt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
